FILE: rtl/core/olt_pkg.sv
`default_nettype none

package olt_pkg;

  localparam int CAPACITY = 16;

  // Field widths of one transaction on either channel.
  localparam int ACTION_W  = 2;
  localparam int POS_W     = 5;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 64;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;

  localparam int ENTRY_W = KEY_W + PAYLOAD_W;
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FLUSH,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/olt_if.sv
`default_nettype none

interface olt_req_if;
  logic                           valid;
  logic                           ready;
  logic [olt_pkg::ACTION_W-1:0]   action;
  logic [olt_pkg::POS_W-1:0]      position;
  logic [olt_pkg::KEY_W-1:0]      key;
  logic [olt_pkg::PAYLOAD_W-1:0]  payload;

  modport source (output valid, action, position, key, payload, input ready);
  modport sink   (input valid, action, position, key, payload, output ready);
endinterface

interface olt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [olt_pkg::STATUS_W-1:0]   status;
  logic [olt_pkg::PAYLOAD_W-1:0]  found_payload;
  logic [olt_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, status, found_payload, entry_count, input ready);
  modport sink   (input valid, status, found_payload, entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ordered_list_table_top.sv
// Ordered list table: a bounded list of up to CAPACITY entries, each a 32-bit
// key with a 64-bit payload, kept in one single-port-write RAM.
//
// req channel (valid/ready): one transaction is one action: insert at a
// position, remove at a position, or look up a key. rsp channel: exactly one
// transaction per action with status, found payload and the entry count
// after the action.
//
// One action is handled at a time; req.ready is high only while idle. Insert
// and remove walk the entries that move, one RAM read and write a cycle;
// lookup walks every entry, one compare a cycle. A failed action or one that
// moves nothing goes straight to its final step, an append first places the
// new entry, an insert walks, flushes the last write and places the new entry,
// and a remove or lookup walks, then flushes. After the response is loaded the
// block returns to idle before the next accept.
//
// Reset (rst, synchronous) empties the list; RAM contents are not cleared since
// only entries below the count are ever read. A stalled receiver holds the
// result in the output register; the next action may be accepted meanwhile and
// waits in its final step until the output register is free.

`default_nettype none

module ordered_list_table_top (
  input  wire logic  clk,
  input  wire logic  rst,
  olt_req_if.sink    req,
  olt_rsp_if.source  rsp
);

  localparam int IDX_W = olt_pkg::IDX_W;
  localparam int CNT_W = olt_pkg::CNT_W;
  localparam int CMP_W = olt_pkg::CMP_W;

  olt_pkg::state_t  state, state_next;
  logic [olt_pkg::ACTION_W-1:0]  op, op_next;
  logic [IDX_W-1:0]              pos_q, pos_q_next;
  logic [olt_pkg::KEY_W-1:0]     key_q, key_q_next;
  logic [olt_pkg::PAYLOAD_W-1:0] pay_q, pay_q_next;
  logic [CNT_W-1:0]              len, len_next;
  logic [IDX_W-1:0]              idx, idx_next;
  logic [IDX_W-1:0]              last_idx, last_idx_next;
  logic                          rd_valid, rd_valid_next;
  logic [IDX_W-1:0]              rd_addr, rd_addr_next;
  olt_pkg::status_t              st_q, st_q_next;
  logic [olt_pkg::PAYLOAD_W-1:0] found_q, found_q_next;

  logic                            rsp_valid, rsp_valid_next;
  logic                            rsp_load;
  logic [olt_pkg::STATUS_W-1:0]    rsp_status;
  logic [olt_pkg::PAYLOAD_W-1:0]   rsp_found;
  logic [olt_pkg::COUNT_W-1:0]     rsp_count;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [olt_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [olt_pkg::ENTRY_W-1:0]   ram_rdata;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic             accept;
  logic             key_hit;

  olt_ram #(
    .WIDTH (olt_pkg::ENTRY_W),
    .DEPTH (olt_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == olt_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign pos_ext   = CMP_W'(req.position);
  assign len_ext   = CMP_W'(len);

  assign key_hit = rd_valid && (op == olt_pkg::ACT_LOOKUP) &&
                   (ram_rdata[olt_pkg::ENTRY_W-1 -: olt_pkg::KEY_W] == key_q);

  // Moved entries are written in the cycle after their read; the new entry
  // goes in after the walk.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {key_q, pay_q};
    if (rd_valid && (op != olt_pkg::ACT_LOOKUP)) begin
      ram_we    = 1'b1;
      ram_waddr = (op == olt_pkg::ACT_INSERT) ? rd_addr + IDX_W'(1) : rd_addr - IDX_W'(1);
      ram_wdata = ram_rdata;
    end else if (state == olt_pkg::S_PLACE) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    pos_q_next    = pos_q;
    key_q_next    = key_q;
    pay_q_next    = pay_q;
    len_next      = len;
    idx_next      = idx;
    last_idx_next = last_idx;
    rd_valid_next = 1'b0;
    rd_addr_next  = rd_addr;
    st_q_next     = st_q;
    found_q_next  = found_q;
    rsp_load      = 1'b0;

    if (key_hit) begin
      found_q_next = ram_rdata[olt_pkg::PAYLOAD_W-1:0];
      st_q_next    = olt_pkg::ST_OK;
    end

    case (state)
      olt_pkg::S_IDLE: begin
        if (accept) begin
          op_next      = req.action;
          pos_q_next   = IDX_W'(req.position);
          key_q_next   = req.key;
          pay_q_next   = req.payload;
          found_q_next = '0;
          state_next   = olt_pkg::S_DONE;
          case (req.action)
            olt_pkg::ACT_INSERT: begin
              if (len == CNT_W'(olt_pkg::CAPACITY)) begin
                st_q_next = olt_pkg::ST_FULL;
              end else if (pos_ext > len_ext) begin
                st_q_next = olt_pkg::ST_BADPOS;
              end else begin
                st_q_next = olt_pkg::ST_OK;
                len_next  = len + CNT_W'(1);
                if (pos_ext == len_ext) begin
                  state_next = olt_pkg::S_PLACE;
                end else begin
                  idx_next      = IDX_W'(len - CNT_W'(1));
                  last_idx_next = IDX_W'(req.position);
                  state_next    = olt_pkg::S_SHIFT;
                end
              end
            end
            olt_pkg::ACT_REMOVE: begin
              if (len == '0) begin
                st_q_next = olt_pkg::ST_EMPTY;
              end else if (pos_ext >= len_ext) begin
                st_q_next = olt_pkg::ST_BADPOS;
              end else begin
                st_q_next = olt_pkg::ST_OK;
                len_next  = len - CNT_W'(1);
                if (pos_ext != len_ext - CMP_W'(1)) begin
                  idx_next      = IDX_W'(req.position) + IDX_W'(1);
                  last_idx_next = IDX_W'(len - CNT_W'(1));
                  state_next    = olt_pkg::S_SHIFT;
                end
              end
            end
            olt_pkg::ACT_LOOKUP: begin
              if (len == '0) begin
                st_q_next = olt_pkg::ST_EMPTY;
              end else begin
                st_q_next     = olt_pkg::ST_NOTFOUND;
                idx_next      = '0;
                last_idx_next = IDX_W'(len - CNT_W'(1));
                state_next    = olt_pkg::S_SHIFT;
              end
            end
            default: begin
              st_q_next = olt_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      olt_pkg::S_SHIFT: begin
        rd_valid_next = 1'b1;
        rd_addr_next  = idx;
        if (idx == last_idx) begin
          state_next = olt_pkg::S_FLUSH;
        end else if (op == olt_pkg::ACT_INSERT) begin
          idx_next = idx - IDX_W'(1);
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      olt_pkg::S_FLUSH: begin
        state_next = (op == olt_pkg::ACT_INSERT) ? olt_pkg::S_PLACE : olt_pkg::S_DONE;
      end
      olt_pkg::S_PLACE: begin
        state_next = olt_pkg::S_DONE;
      end
      olt_pkg::S_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = olt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = olt_pkg::S_IDLE;
      end
    endcase

    rsp_valid_next = (rsp_valid && !rsp.ready) || rsp_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olt_pkg::S_IDLE;
      len       <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      rd_valid  <= rd_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    pos_q    <= pos_q_next;
    key_q    <= key_q_next;
    pay_q    <= pay_q_next;
    idx      <= idx_next;
    last_idx <= last_idx_next;
    rd_addr  <= rd_addr_next;
    st_q     <= st_q_next;
    found_q  <= found_q_next;
    if (rsp_load) begin
      rsp_status <= st_q;
      rsp_found  <= found_q;
      rsp_count  <= olt_pkg::COUNT_W'(len);
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.found_payload = rsp_found;
  assign rsp.entry_count   = rsp_count;

endmodule

`default_nettype wire

FILE: rtl/core/olt_ram.sv
`default_nettype none

module olt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/olt_checker.sv
`default_nettype none

module olt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [olt_pkg::STATUS_W-1:0]    status,
  input wire logic [olt_pkg::PAYLOAD_W-1:0]   found_payload,
  input wire logic [olt_pkg::COUNT_W-1:0]     entry_count
);

  // one action in flight: no accept right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req accepted while previous action in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(found_payload) && $stable(entry_count))
    else $error("stalled rsp transaction changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == olt_pkg::ST_OK) || (status == olt_pkg::ST_FULL) ||
      (status == olt_pkg::ST_EMPTY) || (status == olt_pkg::ST_BADPOS) ||
      (status == olt_pkg::ST_NOTFOUND))
    else $error("rsp status out of range");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != olt_pkg::ST_OK) |-> found_payload == '0)
    else $error("found_payload nonzero on failed action");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == olt_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind ordered_list_table_top olt_checker u_olt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .found_payload (rsp.found_payload),
  .entry_count   (rsp.entry_count)
);

`default_nettype wire
